// ----- hw/rtl/bds_pkg.sv -----
`timescale 1ns / 1ps

package bds_pkg;

    // Widths of the word fields and of the working values.
    localparam int BaudWidth = 24;
    localparam int GenWidth  = 32;
    localparam int DivWidth  = 9;
    localparam int DataWidth = 32;

    // Search range and acceptance limits.
    localparam logic [DivWidth-1:0] DivFirst = 9'd4;
    localparam logic [DivWidth-1:0] DivLast  = 9'd255;
    localparam logic [6:0]          ErrScale = 7'd100;
    localparam logic [1:0]          ErrLimit = 2'd3;

    // Register index of the reference clock on the configuration port.
    localparam logic RegRefClock = 1'b0;

    // Reset value of the reference clock register.
    localparam logic [DataWidth-1:0] RefClockReset = 32'd100000000;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_DIV1,
        ST_WAIT1,
        ST_CHK1,
        ST_MUL2,
        ST_DIV2,
        ST_WAIT2,
        ST_CHK2,
        ST_DONE
    } bds_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_input;
        logic load_den1;
        logic load_den2;
        logic start_div;
        logic load_gen;
        logic load_err;
        logic next_div;
        logic set_hit;
        logic load_result;
    } bds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic gen_ok;
        logic err_ok;
        logic last_div;
        logic out_free;
    } bds_status_t;

endpackage

// ----- hw/rtl/baud_divisor_search_top.sv -----
`timescale 1ns / 1ps
// Throughput: one word at a time; each trial runs on the shared divider,
// which produces one quotient bit per cycle for each division.
// Reset: synchronous, active low; the reference clock returns to 100 MHz.

module baud_divisor_search_top
    import bds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    // Request words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BaudWidth-1:0] s_baud_rate,
    // Result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [GenWidth-1:0]  m_generator_value,
    output logic [DivWidth-1:0]  m_divisor_value,
    output logic                 m_found
);

    logic [DataWidth-1:0] ref_clock_hz_reg, ref_clock_hz_next;
    logic                 cfg_write;
    bds_cmd_t             cmd;
    bds_status_t          status;

    // Reference clock register.
    always_comb begin
        cfg_write         = psel && penable && pwrite && pready;
        ref_clock_hz_next = ref_clock_hz_reg;
        if (cfg_write && (paddr[2] == RegRefClock)) begin
            ref_clock_hz_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_clock_hz_reg <= RefClockReset;
        end else begin
            ref_clock_hz_reg <= ref_clock_hz_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == RegRefClock) ? ref_clock_hz_reg : '0;

    bds_controller u_controller (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bds_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .ref_clock     (ref_clock_hz_reg),
        .baud_in       (s_baud_rate),
        .out_ready     (m_ready),
        .out_valid     (m_valid),
        .out_generator (m_generator_value),
        .out_divisor   (m_divisor_value),
        .out_found     (m_found)
    );

    // A found word carries a generator in range.
    a_found_gen_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |->
            (m_generator_value != 32'd0) && (m_generator_value <= 32'd65535))
        else $error("found result with generator out of range");

    // A found word carries a divisor inside the search range.
    a_found_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_divisor_value >= DivFirst) && (m_divisor_value <= DivLast))
        else $error("found result with divisor out of range");

    // An exhausted search always reports the end-of-range divisor.
    a_miss_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_found) |-> (m_divisor_value == 9'd256))
        else $error("unfound result without end-of-range divisor");

endmodule

// ----- hw/rtl/bds_divider.sv -----
`timescale 1ns / 1ps

module bds_divider
    import bds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DataWidth-1:0] numerator,
    input  logic [DataWidth-1:0] denominator,
    output logic                 done,
    output logic [DataWidth-1:0] quotient
);

    localparam int CntWidth = $clog2(DataWidth + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic [DataWidth-1:0] quot_reg, quot_next;
    logic [DataWidth-1:0] rem_reg, rem_next;
    logic [DataWidth-1:0] den_reg, den_next;
    logic [DataWidth:0]   trial;
    logic                 fits;

    // One restoring step per cycle; a zero denominator yields all ones.
    always_comb begin
        trial = {rem_reg, quot_reg[DataWidth-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CntWidth'(DataWidth);
            quot_next = numerator;
            rem_next  = '0;
            den_next  = denominator;
        end else if (busy_reg) begin
            cnt_next  = cnt_reg - CntWidth'(1);
            quot_next = {quot_reg[DataWidth-2:0], fits};
            rem_next  = fits ? DataWidth'(trial - {1'b0, den_reg}) : trial[DataWidth-1:0];
            if (cnt_reg == CntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ----- hw/rtl/bds_datapath.sv -----
`timescale 1ns / 1ps

module bds_datapath
    import bds_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bds_cmd_t             cmd,
    output bds_status_t          status,
    input  logic [DataWidth-1:0] ref_clock,
    input  logic [BaudWidth-1:0] baud_in,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [GenWidth-1:0]  out_generator,
    output logic [DivWidth-1:0]  out_divisor,
    output logic                 out_found
);

    logic [BaudWidth-1:0] baud_reg, baud_next;
    logic [DivWidth-1:0]  div_reg, div_next;
    logic [DataWidth-1:0] den_reg, den_next;
    logic [GenWidth-1:0]  gen_reg, gen_next;
    logic [DataWidth-1:0] err_reg, err_next;
    logic                 hit_reg, hit_next;
    logic                 m_valid_reg, m_valid_next;
    logic [GenWidth-1:0]  m_gen_reg, m_gen_next;
    logic [DivWidth-1:0]  m_div_reg, m_div_next;
    logic                 m_found_reg, m_found_next;

    logic [DivWidth-1:0]  div_plus;
    logic [DataWidth-1:0] den1_full;
    logic [24:0]          den2_full;
    logic                 q_done;
    logic [DataWidth-1:0] q_value;
    logic [DataWidth-1:0] err_diff;
    logic [38:0]          err_scaled;
    logic [25:0]          err_bound;

    // Shared serial divider: the reference clock over the current denominator.
    bds_divider u_divider (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (cmd.start_div),
        .numerator   (ref_clock),
        .denominator (den_reg),
        .done        (q_done),
        .quotient    (q_value)
    );

    // Denominators for the generator and for the achieved rate.
    // The request times at most 256 always fits in 32 bits.
    always_comb begin
        div_plus  = div_reg + DivWidth'(1);
        den1_full = DataWidth'(baud_reg) * DataWidth'(div_plus);
        den2_full = 25'(gen_reg[15:0]) * 25'(div_plus);
    end

    // Distance of the achieved rate from the request, and the percentage test.
    always_comb begin
        if ({8'd0, baud_reg} >= q_value) begin
            err_diff = {8'd0, baud_reg} - q_value;
        end else begin
            err_diff = q_value - {8'd0, baud_reg};
        end
        err_scaled = 39'(err_reg) * 39'(ErrScale);
        err_bound  = 26'(baud_reg) * 26'(ErrLimit);
    end

    // Working registers.
    always_comb begin
        baud_next = baud_reg;
        div_next  = div_reg;
        den_next  = den_reg;
        gen_next  = gen_reg;
        err_next  = err_reg;
        hit_next  = hit_reg;
        if (cmd.load_input) begin
            baud_next = baud_in;
            div_next  = DivFirst;
            hit_next  = 1'b0;
            gen_next  = '0;
        end
        if (cmd.load_den1) begin
            den_next = den1_full;
        end
        if (cmd.load_den2) begin
            den_next = {7'd0, den2_full};
        end
        if (cmd.load_gen) begin
            gen_next = q_value;
        end
        if (cmd.load_err) begin
            err_next = err_diff;
        end
        if (cmd.next_div) begin
            div_next = div_plus;
        end
        if (cmd.set_hit) begin
            hit_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        baud_reg <= baud_next;
        div_reg  <= div_next;
        den_reg  <= den_next;
        gen_reg  <= gen_next;
        err_reg  <= err_next;
        hit_reg  <= hit_next;
    end

    // Output register: holds a finished word until it is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_gen_next   = m_gen_reg;
        m_div_next   = m_div_reg;
        m_found_next = m_found_reg;
        if (out_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
            m_gen_next   = gen_reg;
            m_div_next   = div_reg;
            m_found_next = hit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_gen_reg   <= m_gen_next;
        m_div_reg   <= m_div_next;
        m_found_reg <= m_found_next;
    end

    // Status back to the controller.
    always_comb begin
        status.div_done = q_done;
        status.gen_ok   = (gen_reg != '0) && (gen_reg[GenWidth-1:16] == '0);
        status.err_ok   = (baud_reg != '0) && (err_scaled < {13'd0, err_bound});
        status.last_div = div_reg == DivLast;
        status.out_free = !m_valid_reg || out_ready;
    end

    assign out_valid     = m_valid_reg;
    assign out_generator = m_gen_reg;
    assign out_divisor   = m_div_reg;
    assign out_found     = m_found_reg;

endmodule

// ----- hw/rtl/bds_controller.sv -----
`timescale 1ns / 1ps

module bds_controller
    import bds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  bds_status_t status,
    output bds_cmd_t    cmd
);

    bds_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state: one divisor trial after another until a hit or the end.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:  state_next = ST_DIV1;
            ST_DIV1:  state_next = ST_WAIT1;
            ST_WAIT1: begin
                if (status.div_done) begin
                    state_next = ST_CHK1;
                end
            end
            ST_CHK1: begin
                if (status.gen_ok) begin
                    state_next = ST_MUL2;
                end else if (status.last_div) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL2:  state_next = ST_DIV2;
            ST_DIV2:  state_next = ST_WAIT2;
            ST_WAIT2: begin
                if (status.div_done) begin
                    state_next = ST_CHK2;
                end
            end
            ST_CHK2: begin
                if (status.err_ok || status.last_div) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.load_input = in_valid;
            end
            ST_MUL1:  cmd.load_den1 = 1'b1;
            ST_DIV1:  cmd.start_div = 1'b1;
            ST_WAIT1: cmd.load_gen  = status.div_done;
            ST_CHK1:  cmd.next_div  = !status.gen_ok;
            ST_MUL2:  cmd.load_den2 = 1'b1;
            ST_DIV2:  cmd.start_div = 1'b1;
            ST_WAIT2: cmd.load_err  = status.div_done;
            ST_CHK2: begin
                cmd.set_hit  = status.err_ok;
                cmd.next_div = !status.err_ok;
            end
            ST_DONE:  cmd.load_result = status.out_free;
            default: begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- test/baud_divisor_search_top_tb.sv -----
`timescale 1ns / 1ps

module baud_divisor_search_top_tb;
    import bds_pkg::*;

    // Limits of the search that the package does not give.
    localparam logic [63:0]          GenMax       = 64'd65535;
    localparam logic [DivWidth-1:0]  DivExhausted = 9'd256;
    localparam logic [2:0]           RefClockAddr = 3'd4 * RegRefClock;

    // Stimulus shaping and run control.
    localparam int      DirectedCount   = 20;
    localparam int      ItemsPerPhase   = 20;
    localparam int      MinTypicalGen   = 8;
    localparam int      RxHoldCycles    = 3000;
    localparam int      SettleCycles    = 20000;
    localparam longint  TimeoutNs       = 200_000_000;

    typedef struct packed {
        logic [GenWidth-1:0] generator;
        logic [DivWidth-1:0] divisor;
        logic                found;
    } search_result_t;

    // One row of the directed table: the clock setting, the request and,
    // where it is obvious, the result written out by hand.
    typedef struct packed {
        logic [DataWidth-1:0] clk_hz;
        logic [BaudWidth-1:0] baud;
        logic                 has_want;
        search_result_t       want;
    } baud_case_t;

    localparam search_result_t Predicted = '0;

    logic                 aclk;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [DataWidth-1:0] pwdata;
    logic [DataWidth-1:0] prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [BaudWidth-1:0] s_baud_rate;
    logic                 m_valid;
    logic                 m_ready;
    logic [GenWidth-1:0]  m_generator_value;
    logic [DivWidth-1:0]  m_divisor_value;
    logic                 m_found;

    // Local copy of the clock register and the results still owed by the block.
    logic [DataWidth-1:0] ref_clock_hz = RefClockReset;
    search_result_t       pending_results [$];
    int                   failures      = 0;
    int                   tx_idle_pct   = 0;
    int                   rx_idle_pct   = 0;
    int                   hold_requests = 0;

    baud_case_t directed_cases [DirectedCount] = '{
        '{RefClockReset, 24'd0,        1'b1, '{32'hFFFF_FFFF, DivExhausted, 1'b0}},
        '{RefClockReset, 24'd115200,   1'b1, '{32'd173, 9'd4, 1'b1}},
        '{RefClockReset, 24'hFF_FFFF,  1'b1, '{32'd0, DivExhausted, 1'b0}},
        '{RefClockReset, 24'd1,        1'b0, Predicted},
        '{RefClockReset, 24'd300,      1'b0, Predicted},
        '{RefClockReset, 24'd9600,     1'b0, Predicted},
        '{RefClockReset, 24'd1000000,  1'b0, Predicted},
        '{RefClockReset, 24'h55_5555,  1'b0, Predicted},
        '{RefClockReset, 24'hAA_AAAA,  1'b0, Predicted},
        '{RefClockReset, 24'h80_0000,  1'b0, Predicted},
        '{RefClockReset, 24'h7F_FFFF,  1'b0, Predicted},
        '{32'd0,         24'd9600,     1'b1, '{32'd0, DivExhausted, 1'b0}},
        '{32'd0,         24'd0,        1'b1, '{32'hFFFF_FFFF, DivExhausted, 1'b0}},
        '{32'd0,         24'hFF_FFFF,  1'b1, '{32'd0, DivExhausted, 1'b0}},
        '{32'd1,         24'd1,        1'b1, '{32'd0, DivExhausted, 1'b0}},
        '{32'hFFFF_FFFF, 24'd1,        1'b0, Predicted},
        '{32'hFFFF_FFFF, 24'hFF_FFFF,  1'b0, Predicted},
        '{32'hFFFF_FFFF, 24'd115200,   1'b0, Predicted},
        '{32'hFFFF_FFFF, 24'd0,        1'b1, '{32'hFFFF_FFFF, DivExhausted, 1'b0}},
        '{RefClockReset, 24'd19200,    1'b0, Predicted}
    };

    baud_divisor_search_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_baud_rate       (s_baud_rate),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_generator_value (m_generator_value),
        .m_divisor_value   (m_divisor_value),
        .m_found           (m_found)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Walk the divisors in order and stop at the first one whose achieved rate
    // is within three percent; a zero denominator gives all ones.
    function automatic search_result_t predict_search(input logic [DataWidth-1:0] clk_hz,
                                                      input logic [BaudWidth-1:0] baud);
        search_result_t r;
        logic [63:0]    den;
        logic [63:0]    gen;
        logic [63:0]    rate;
        logic [63:0]    err;
        int unsigned    d;
        r.generator = '0;
        r.divisor   = DivExhausted;
        r.found     = 1'b0;
        gen         = '0;
        for (d = DivFirst; d <= DivLast; d++) begin
            den = 64'(baud) * (d + 1);
            gen = (den == 0) ? 64'hFFFF_FFFF : 64'(clk_hz) / den;
            if (gen < 1 || gen > GenMax) continue;
            rate = 64'(clk_hz) / (gen * (d + 1));
            err  = (64'(baud) >= rate) ? 64'(baud) - rate : rate - 64'(baud);
            if (baud != 0 && (err * ErrScale) / 64'(baud) < ErrLimit) begin
                r.found   = 1'b1;
                r.divisor = 9'(d);
                break;
            end
        end
        r.generator = gen[31:0];
        return r;
    endfunction

    // Mostly rates that give a usable generator at the first divisor, with a
    // quarter of fully random requests that may run the search out.
    function automatic logic [BaudWidth-1:0] pick_baud(input logic [DataWidth-1:0] clk_hz);
        logic [63:0]          lowest;
        logic [63:0]          highest;
        logic [BaudWidth-1:0] wild;
        wild    = 24'($urandom);
        lowest  = 64'(clk_hz) / ((DivFirst + 1) * (GenMax + 1)) + 1;
        highest = 64'(clk_hz) / ((DivFirst + 1) * MinTypicalGen);
        if (highest > 64'hFF_FFFF) highest = 64'hFF_FFFF;
        if ($urandom_range(0, 3) == 0 || lowest > highest) return wild;
        return 24'($urandom_range(32'(highest), 32'(lowest)));
    endfunction

    // Offer one request word, with random gaps before it, and log its result.
    task automatic send_baud(input logic [BaudWidth-1:0] baud, input search_result_t want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_baud_rate <= baud;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(want);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    // Write the reference clock register, then read it back.
    task automatic write_ref_clock(input logic [DataWidth-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RefClockAddr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        ref_clock_hz = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== value) begin
            $display("%0t: ref clock readback: expected %0d, got %0d", $time, value, prdata);
            failures++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin : result_ready
        int holds_served;
        holds_served = 0;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (RxHoldCycles) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Compare every accepted result word with the oldest one owed.
    always @(posedge aclk) begin : result_check
        search_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: gen %0d div %0d found %0b",
                         $time, m_generator_value, m_divisor_value, m_found);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (m_generator_value !== want.generator) begin
                    $display("%0t: generator: expected %0d, got %0d",
                             $time, want.generator, m_generator_value);
                    failures++;
                end
                if (m_divisor_value !== want.divisor) begin
                    $display("%0t: divisor: expected %0d, got %0d",
                             $time, want.divisor, m_divisor_value);
                    failures++;
                end
                if (m_found !== want.found) begin
                    $display("%0t: found: expected %0b, got %0b", $time, want.found, m_found);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then four random phases.
    initial begin : stimulus
        int                   i;
        int                   phase;
        int                   n;
        baud_case_t           row;
        logic [BaudWidth-1:0] baud;
        logic [DataWidth-1:0] clk_next;
        aresetn     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_valid     = 1'b0;
        s_baud_rate = '0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // The opening rows rely on the reset value of the clock register.
        for (i = 0; i < DirectedCount; i++) begin
            row = directed_cases[i];
            if (row.clk_hz != ref_clock_hz) begin
                s_valid <= 1'b0;
                wait_drained();
                write_ref_clock(row.clk_hz);
            end
            send_baud(row.baud, row.has_want ? row.want
                                             : predict_search(ref_clock_hz, row.baud));
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 9;
                    rx_idle_pct = 86;
                    clk_next    = 32'd100_000_000;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 9;
                    clk_next    = 32'd48_000_000;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    clk_next    = $urandom_range(32'hFFFF_FFFF, 32'd1_000_000);
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    clk_next    = 32'hFFFF_FFFF;
                end
            endcase
            s_valid <= 1'b0;
            wait_drained();
            write_ref_clock(clk_next);
            // Hold the result side off so that the block backs up onto its input.
            if (phase == 2) hold_requests++;
            for (n = 0; n < ItemsPerPhase; n++) begin
                // Halfway through the last phase, let the block empty completely.
                if (phase == 3 && n == ItemsPerPhase / 2) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
                baud = pick_baud(ref_clock_hz);
                send_baud(baud, predict_search(ref_clock_hz, baud));
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        repeat (SettleCycles) @(negedge aclk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("Test completed with failures");
        $finish;
    end

endmodule
